@@ rtl/bcpa_pkg.sv @@
// Shared types, constants and helpers for the bitmap contiguous page allocator.
`default_nettype none
package bcpa_pkg;

    // Arena geometry: pages are kept in bitmap words of WORD_W bits.
    localparam int PAGES  = 128;
    localparam int WORD_W = 32;
    localparam int WBITS  = $clog2(WORD_W);
    localparam int NWORDS = PAGES / WORD_W;
    localparam int WA     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    // Page position width, wide enough to hold PAGES itself.
    localparam int PB     = $clog2(PAGES) + 1;
    // Pages examined per search cycle.
    localparam int CHUNK  = 8;
    localparam int CBITS  = $clog2(CHUNK);

    // Action codes; the last one is reserved and rejected.
    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_FREE   = 2'd1;
    localparam logic [1:0] ACT_DECOM  = 2'd2;
    localparam logic [1:0] ACT_RSVD   = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    // Configuration register index.
    localparam logic REG_SPREAD = 1'b0;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] page_count;
        logic [6:0] page_index;
    } t_cmd;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] start_page;
        logic       needs_commit;
        logic       any_decommitted;
        logic       arena_in_use;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SSTART,
        S_SRD,
        S_SLD,
        S_SCHK,
        S_PRD,
        S_PEX,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        P_MARK,
        P_CHECK,
        P_CLEAR,
        P_DECOM,
        P_ANY
    } t_pass;

    // Bitmap word that holds a page.
    function automatic logic [WA-1:0] word_of(input logic [PB-1:0] page);
        word_of = WA'(page >> WBITS);
    endfunction

    // Bits of word w that fall inside the page range lo..hi.
    function automatic logic [WORD_W-1:0] range_mask(input logic [WA-1:0] w,
                                                     input logic [PB-1:0] lo,
                                                     input logic [PB-1:0] hi);
        logic [WORD_W-1:0] m;
        int                pg;
        m = '0;
        for (int b = 0; b < WORD_W; b++) begin
            pg = int'(w) * WORD_W + b;
            m[b] = (pg >= int'(lo)) && (pg <= int'(hi));
        end
        range_mask = m;
    endfunction

endpackage
`default_nettype wire

@@ rtl/bcpa_ram.sv @@
// Generic single-port-write, registered-read RAM.
`default_nettype none
module bcpa_ram #(
    parameter int W = 32,
    parameter int D = 4
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_we,
    input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  wire logic [W-1:0]                        i_wdata,
    input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic      [W-1:0]                        o_rdata
);
    logic [W-1:0] r_mem [D];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/bcpa_cfg.sv @@
// APB configuration register block holding the spread mode bit.
`default_nettype none
module bcpa_cfg import bcpa_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic             o_spread
);
    logic r_spread;
    logic w_wr;

    // A transaction writes on the access cycle.
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spread <= 1'b0;
        end else if (w_wr && (paddr[2] == REG_SPREAD)) begin
            r_spread <= pwdata[0];
        end
    end

    // Read data; the low address bits select a byte and are ignored.
    assign prdata   = (paddr[2] == REG_SPREAD) ? {31'b0, r_spread} : 32'b0;
    assign o_spread = r_spread;
endmodule
`default_nettype wire

@@ rtl/bcpa_ctrl.sv @@
// Sequencer that searches and updates the used and committed bitmaps.
`default_nettype none
module bcpa_ctrl import bcpa_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_spread,
    input  wire logic       i_start,
    input  wire t_cmd       i_cmd,
    output logic            o_busy,
    output logic            o_done,
    output t_result         o_result
);
    // Bitmap memories.
    logic              w_we;
    logic [WA-1:0]     w_raddr;
    logic [WORD_W-1:0] w_used_wd, w_comm_wd, w_used_rd, w_comm_rd;
    logic [WA-1:0]     r_w, n_w;

    bcpa_ram #(.W(WORD_W), .D(NWORDS)) u_used (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(r_w), .i_wdata(w_used_wd),
        .i_raddr(w_raddr), .o_rdata(w_used_rd)
    );
    bcpa_ram #(.W(WORD_W), .D(NWORDS)) u_comm (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(r_w), .i_wdata(w_comm_wd),
        .i_raddr(w_raddr), .o_rdata(w_comm_rd)
    );

    t_state            r_state, n_state;
    t_pass             r_pass, n_pass;
    logic [1:0]        r_action, n_action;
    logic [7:0]        r_count, n_count;
    logic [PB-1:0]     r_ns, n_ns;
    logic              r_second, n_second;
    logic [PB-1:0]     r_p, n_p;
    logic [PB-1:0]     r_last, n_last;
    logic [7:0]        r_run, n_run;
    logic [WORD_W-1:0] r_word, n_word;
    logic [WA-1:0]     r_wlast, n_wlast;
    logic [PB-1:0]     r_lo, n_lo;
    logic [PB-1:0]     r_hi, n_hi;
    logic [1:0]        r_status, n_status;
    logic              r_ok_alloc, n_ok_alloc;
    logic              r_need, n_need;
    logic              r_dec, n_dec;
    logic              r_any, n_any;
    logic              r_bad, n_bad;
    logic [NWORDS-1:0] r_vld, n_vld;

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ns    <= '0;
            r_vld   <= '0;
        end else begin
            r_state <= n_state;
            r_ns    <= n_ns;
            r_vld   <= n_vld;
        end
    end

    // Per-request working registers.
    always_ff @(posedge i_clk) begin
        r_pass     <= n_pass;
        r_action   <= n_action;
        r_count    <= n_count;
        r_second   <= n_second;
        r_p        <= n_p;
        r_last     <= n_last;
        r_run      <= n_run;
        r_word     <= n_word;
        r_w        <= n_w;
        r_wlast    <= n_wlast;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_status   <= n_status;
        r_ok_alloc <= n_ok_alloc;
        r_need     <= n_need;
        r_dec      <= n_dec;
        r_any      <= n_any;
        r_bad      <= n_bad;
    end

    // Next state, memory access and result tracking.
    always_comb begin
        logic [WORD_W-1:0] ru, rc, m;
        logic [PB-1:0]     base, idx, s_found, p_next;
        logic [7:0]        run;
        logic              found;
        logic [PB+1:0]     lim, fend;

        ru = r_vld[r_w] ? w_used_rd : '0;
        rc = r_vld[r_w] ? w_comm_rd : '0;
        m  = range_mask(r_w, r_lo, r_hi);
        base = {r_p[PB-1:CBITS], CBITS'(0)};
        idx = '0; s_found = '0; run = r_run; found = 1'b0;
        p_next = base + PB'(CHUNK);
        lim  = (PB+2)'(r_ns) + (PB+2)'(r_count) - (PB+2)'(1);
        fend = (PB+2)'(i_cmd.page_index) + (PB+2)'(i_cmd.page_count);

        n_state = r_state; n_pass = r_pass; n_action = r_action; n_count = r_count;
        n_ns = r_ns; n_second = r_second; n_p = r_p; n_last = r_last; n_run = r_run;
        n_word = r_word; n_w = r_w; n_wlast = r_wlast; n_lo = r_lo; n_hi = r_hi;
        n_status = r_status; n_ok_alloc = r_ok_alloc; n_need = r_need; n_dec = r_dec;
        n_any = r_any; n_bad = r_bad; n_vld = r_vld;
        w_we = 1'b0; w_raddr = r_w; w_used_wd = ru; w_comm_wd = rc;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_action = i_cmd.action; n_count = i_cmd.page_count;
                    n_status = ST_OK; n_ok_alloc = 1'b0; n_need = 1'b0;
                    n_dec = 1'b0; n_any = 1'b0; n_bad = 1'b0; n_second = 1'b0;
                    n_run = '0;
                    // Default path: report an error after the occupancy scan.
                    n_status = ST_BAD; n_pass = P_ANY; n_w = '0;
                    n_wlast = WA'(NWORDS - 1); n_state = S_PRD;
                    case (i_cmd.action)
                        ACT_ALLOC: begin
                            if (i_cmd.page_count != '0) begin
                                n_status = ST_OK;
                                n_p      = i_spread ? r_ns : '0;
                                n_last   = PB'(PAGES - 1);
                                n_second = !i_spread;
                                n_state  = S_SSTART;
                            end
                        end
                        ACT_FREE: begin
                            if (i_cmd.page_count != '0 && fend <= (PB+2)'(PAGES)) begin
                                n_status = ST_OK;
                                n_lo     = PB'(i_cmd.page_index);
                                n_hi     = PB'(fend - (PB+2)'(1));
                                n_w      = word_of(PB'(i_cmd.page_index));
                                n_wlast  = word_of(PB'(fend - (PB+2)'(1)));
                                n_pass   = P_CHECK;
                            end
                        end
                        ACT_DECOM: begin
                            n_status = ST_OK;
                            n_pass   = P_DECOM;
                        end
                        default: ;
                    endcase
                end
            end
            S_SSTART: begin
                n_run = '0;
                if (r_p > r_last) begin
                    // Empty window: retry from zero or give up.
                    if (!r_second) begin
                        n_second = 1'b1; n_p = '0;
                        n_last = (lim > (PB+2)'(PAGES - 1)) ? PB'(PAGES - 1) : PB'(lim);
                    end else begin
                        n_status = ST_NOFIT; n_pass = P_ANY; n_w = '0;
                        n_wlast = WA'(NWORDS - 1); n_state = S_PRD;
                    end
                end else begin
                    n_state = S_SRD;
                end
            end
            S_SRD: begin
                w_raddr = word_of(r_p);
                n_w     = word_of(r_p);
                n_state = S_SLD;
            end
            S_SLD: begin
                n_word  = ru;
                n_state = S_SCHK;
            end
            S_SCHK: begin
                // Walk one chunk of pages, extending the free run.
                for (int j = 0; j < CHUNK; j++) begin
                    idx = base + PB'(j);
                    if (!found && idx >= r_p && idx <= r_last) begin
                        if (r_word[idx[WBITS-1:0]]) begin
                            run = '0;
                        end else begin
                            run = run + 8'd1;
                            if (run == r_count) begin
                                found = 1'b1;
                                s_found = idx + PB'(1) - PB'(r_count);
                            end
                        end
                    end
                end
                n_run = run;
                if (found) begin
                    n_ok_alloc = 1'b1;
                    n_lo = s_found;
                    n_hi = s_found + PB'(r_count) - PB'(1);
                    n_ns = s_found + PB'(r_count);
                    n_w = word_of(s_found);
                    n_wlast = word_of(s_found + PB'(r_count) - PB'(1));
                    n_pass = P_MARK; n_state = S_PRD;
                end else if (base + PB'(CHUNK - 1) >= r_last) begin
                    n_p = r_last + PB'(1);
                    n_state = S_SSTART;
                end else begin
                    n_p = p_next;
                    n_state = (p_next[WBITS-1:0] == '0) ? S_SRD : S_SCHK;
                end
            end
            S_PRD: begin
                n_state = S_PEX;
            end
            S_PEX: begin
                case (r_pass)
                    P_MARK: begin
                        w_we = 1'b1; w_used_wd = ru | m; w_comm_wd = rc | m;
                        n_need = r_need | (|(m & ~rc));
                    end
                    P_CHECK: n_bad = r_bad | ((ru & m) != m);
                    P_CLEAR: begin
                        w_we = 1'b1; w_used_wd = ru & ~m;
                    end
                    P_DECOM: begin
                        w_we = 1'b1; w_comm_wd = rc & ru;
                        n_dec = r_dec | (|(rc & ~ru));
                    end
                    default: n_any = r_any | (|ru);
                endcase
                if (w_we) n_vld[r_w] = 1'b1;
                n_state = S_PRD;
                if (r_w == r_wlast) begin
                    n_w = '0; n_wlast = WA'(NWORDS - 1); n_pass = P_ANY;
                    case (r_pass)
                        P_CHECK: begin
                            if (n_bad) begin
                                n_status = ST_BAD;
                            end else begin
                                n_pass = P_CLEAR; n_w = word_of(r_lo);
                                n_wlast = word_of(r_hi);
                            end
                        end
                        P_ANY: n_state = S_DONE;
                        default: ;
                    endcase
                end else begin
                    n_w = r_w + WA'(1);
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);
    assign o_result.status          = r_status;
    assign o_result.start_page      = r_ok_alloc ? r_lo[6:0] : 7'd0;
    assign o_result.needs_commit    = r_ok_alloc & r_need;
    assign o_result.any_decommitted = r_dec;
    assign o_result.arena_in_use    = r_any;

    // A request ends with exactly one result cycle, then the block is free.
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done && !o_busy) else $error("result not single cycle");
    // Bitmap writes happen only in the execute step of a pass.
    a_we_pex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> r_state == S_PEX) else $error("stray bitmap write");
    // A successful allocation always reports status ok.
    a_alloc_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_ok_alloc) |-> r_status == ST_OK) else $error("alloc status");
endmodule
`default_nettype wire

@@ rtl/bitmap_contiguous_page_allocator_top.sv @@
// Top level of the bitmap contiguous page allocator.
//
//  Channel   Ports                                   Transaction
//  command   start, busy, i_cmd                      start && !busy
//  result    o_done, o_result                        o_done, one cycle
//  config    psel penable pwrite paddr pwdata        psel && penable && pwrite
//            prdata pready
//
// An allocate searches bitmap words, marks the found run and ends with an
// occupancy scan; the search handles eight pages per cycle through the
// used-bitmap read port, pausing to read each new word. Free and decommit
// visit their words before the scan. Reset clears the sequencer and
// the per-word valid bits, so both bitmaps read as clear at once. The result
// is shown for one cycle and cannot be stalled; busy stays high until then.
`default_nettype none
module bitmap_contiguous_page_allocator_top import bcpa_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_cmd        i_cmd,
    output logic             o_done,
    output t_result          o_result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    logic w_spread;

    bcpa_cfg u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .o_spread(w_spread)
    );

    bcpa_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_spread(w_spread), .i_start(start),
        .i_cmd(i_cmd), .o_busy(busy), .o_done(o_done), .o_result(o_result)
    );
endmodule
`default_nettype wire

@@ bench/bitmap_contiguous_page_allocator_top_tb.sv @@
// Testbench for the bitmap contiguous page allocator against a bitmap model.
`default_nettype none
module bitmap_contiguous_page_allocator_top_tb import bcpa_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_cmd        i_cmd;
    logic        o_done;
    t_result     o_result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Model state of the arena.
    logic [PAGES-1:0] used_pages;
    logic [PAGES-1:0] committed_pages;
    int unsigned      next_page;
    logic             spread_on;

    t_result     expected_results[$];
    int unsigned mismatch_count;
    int unsigned send_idle_pct;

    bitmap_contiguous_page_allocator_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_cmd(i_cmd),
        .o_done(o_done), .o_result(o_result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Lowest free run of cnt pages starting at or after lo and ending at or before hi.
    function automatic int find_free_run(int unsigned cnt, int unsigned lo, int unsigned hi);
        int unsigned run;
        run = 0;
        if (cnt == 0 || lo > hi || hi >= PAGES) return -1;
        for (int unsigned p = lo; p <= hi; p++) begin
            if (used_pages[p]) begin
                run = 0;
            end else begin
                run++;
                if (run == cnt) return int'(p + 1 - cnt);
            end
        end
        return -1;
    endfunction

    // Apply one command to the model and return the result it should produce.
    function automatic t_result predict_allocator(t_cmd c);
        t_result     r;
        int          s;
        int unsigned cnt;
        int unsigned idx;
        int unsigned lim;
        r = '0;
        cnt = c.page_count;
        idx = c.page_index;
        if (c.action == ACT_ALLOC) begin
            if (cnt == 0) begin
                r.status = ST_BAD;
            end else begin
                if (spread_on) begin
                    s = find_free_run(cnt, next_page, PAGES - 1);
                    if (s < 0) begin
                        lim = next_page + cnt - 1;
                        if (lim > PAGES - 1) lim = PAGES - 1;
                        s = find_free_run(cnt, 0, lim);
                    end
                end else begin
                    s = find_free_run(cnt, 0, PAGES - 1);
                end
                if (s < 0) begin
                    r.status = ST_NOFIT;
                end else begin
                    r.status = ST_OK;
                    r.start_page = s[6:0];
                    for (int unsigned p = s; p < s + cnt; p++) begin
                        if (!committed_pages[p]) r.needs_commit = 1'b1;
                        used_pages[p] = 1'b1;
                        committed_pages[p] = 1'b1;
                    end
                    next_page = s + cnt;
                end
            end
        end else if (c.action == ACT_FREE) begin
            if (cnt == 0 || idx + cnt > PAGES) begin
                r.status = ST_BAD;
            end else begin
                for (int unsigned p = idx; p < idx + cnt; p++)
                    if (!used_pages[p]) r.status = ST_BAD;
                if (r.status == ST_OK)
                    for (int unsigned p = idx; p < idx + cnt; p++) used_pages[p] = 1'b0;
            end
        end else if (c.action == ACT_DECOM) begin
            for (int p = 0; p < PAGES; p++) begin
                if (!used_pages[p] && committed_pages[p]) begin
                    committed_pages[p] = 1'b0;
                    r.any_decommitted = 1'b1;
                end
            end
        end else begin
            r.status = ST_BAD;
        end
        r.arena_in_use = |used_pages;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Check every result transaction against the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 32'(o_result), 32'd0);
            end else begin
                want = expected_results.pop_front();
                if (o_result.status !== want.status)
                    report_mismatch("status", 32'(o_result.status), 32'(want.status));
                if (o_result.start_page !== want.start_page)
                    report_mismatch("start_page", 32'(o_result.start_page),
                                    32'(want.start_page));
                if (o_result.needs_commit !== want.needs_commit)
                    report_mismatch("needs_commit", 32'(o_result.needs_commit),
                                    32'(want.needs_commit));
                if (o_result.any_decommitted !== want.any_decommitted)
                    report_mismatch("any_decommitted", 32'(o_result.any_decommitted),
                                    32'(want.any_decommitted));
                if (o_result.arena_in_use !== want.arena_in_use)
                    report_mismatch("arena_in_use", 32'(o_result.arena_in_use),
                                    32'(want.arena_in_use));
            end
        end
    end

    // Send one command and predict its result once it is accepted.
    task automatic send_command(logic [1:0] act, logic [7:0] cnt, logic [6:0] idx);
        t_cmd c;
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        c.action = act;
        c.page_count = cnt;
        c.page_index = idx;
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_results.push_back(predict_allocator(c));
        start <= 1'b0;
        // The block is busy now; leave the edge of acceptance before the next command.
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Write the spread register over the configuration port while idle.
    task automatic write_spread(logic val);
        wait_drained();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'(int'(REG_SPREAD) * 4);
        pwdata <= {31'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        spread_on = val;
    endtask

    // Extremes of every field, every action and each special case.
    task automatic test_directed();
        send_command(ACT_DECOM, 8'd0, 7'd0);
        send_command(ACT_ALLOC, 8'd0, 7'd0);
        send_command(ACT_ALLOC, 8'd129, 7'd0);
        send_command(ACT_ALLOC, 8'd255, 7'd127);
        send_command(ACT_ALLOC, 8'd128, 7'd0);
        send_command(ACT_ALLOC, 8'd1, 7'd0);
        send_command(ACT_FREE, 8'd0, 7'd5);
        send_command(ACT_FREE, 8'd2, 7'd127);
        send_command(ACT_FREE, 8'd128, 7'd0);
        send_command(ACT_DECOM, 8'd0, 7'd0);
        send_command(ACT_ALLOC, 8'd4, 7'd0);
        send_command(ACT_ALLOC, 8'd10, 7'd0);
        send_command(ACT_FREE, 8'd20, 7'd0);
        send_command(ACT_FREE, 8'd2, 7'd1);
        send_command(ACT_FREE, 8'd1, 7'd127);
        send_command(ACT_DECOM, 8'd0, 7'd0);
        send_command(ACT_ALLOC, 8'd3, 7'd0);
        send_command(ACT_RSVD, 8'hFF, 7'h7F);
        send_command(ACT_ALLOC, 8'd1, 7'd0);
        send_command(ACT_ALLOC, 8'd117, 7'd0);
        send_command(ACT_ALLOC, 8'd1, 7'd0);
    endtask

    // Mostly well-formed alloc and free traffic that tracks live runs, with some decommit and random commands.
    task automatic test_random(int n);
        int unsigned k;
        int unsigned sel;
        int unsigned cnt;
        int          lo;
        int          len;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            if (sel < 45) begin
                cnt = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(1, 24);
                send_command(ACT_ALLOC, 8'(cnt), 7'($urandom));
            end else if (sel < 85) begin
                // Free a random slice of some used page range when there is one.
                lo = -1;
                k = $urandom_range(PAGES - 1);
                for (int j = 0; j < PAGES; j++)
                    if (lo < 0 && used_pages[(k + j) % PAGES]) lo = (k + j) % PAGES;
                if (lo < 0) lo = k;
                len = 1;
                while (lo + len < PAGES && used_pages[lo + len] && $urandom_range(7) != 0)
                    len++;
                send_command(ACT_FREE, 8'(len), 7'(lo));
            end else if (sel < 92) begin
                send_command(ACT_DECOM, 8'($urandom), 7'($urandom));
            end else begin
                send_command(2'($urandom), 8'($urandom), 7'($urandom));
            end
        end
    endtask

    // Sender pauses until every outstanding result is back, then resumes.
    task automatic test_drain_pause();
        send_command(ACT_ALLOC, 8'd5, 7'd0);
        wait_drained();
        send_command(ACT_FREE, 8'd5, 7'd0);
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        used_pages = '0;
        committed_pages = '0;
        next_page = 0;
        spread_on = 1'b0;
        mismatch_count = 0;
        send_idle_pct = 17;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        write_spread(1'b1);
        test_directed();
        test_random(650);
        test_drain_pause();
        send_idle_pct = 86;
        write_spread(1'b0);
        test_random(200);
        write_spread(1'b1);
        test_random(200);
        send_idle_pct = 0;
        write_spread(1'b0);
        test_random(450);
        write_spread(1'b1);
        test_random(450);

        wait_drained();
        if (mismatch_count == 0) begin
            $display("bitmap_contiguous_page_allocator_top verification clean");
        end else begin
            $display("bitmap_contiguous_page_allocator_top verification failed");
        end
        $finish;
    end

    // Overall time limit.
    initial begin
        #4ms;
        $display("bitmap_contiguous_page_allocator_top verification failed");
        $finish;
    end
endmodule
`default_nettype wire

@@ bitmap_contiguous_page_allocator_top.f @@
rtl/bcpa_pkg.sv
rtl/bcpa_ram.sv
rtl/bcpa_cfg.sv
rtl/bcpa_ctrl.sv
rtl/bitmap_contiguous_page_allocator_top.sv
bench/bitmap_contiguous_page_allocator_top_tb.sv
